>>> rtl/jws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jws_pkg
// Shared constants, types and codes of the joint waypoint sequencer.
// ----------------------------------------------------------------------------

package jws_pkg;

   localparam int JOINTS      = 4;
   localparam int STEPS       = 16;
   localparam int POS_W       = 16;
   localparam int PORT_JOINTS = 4;

   localparam int ROW_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int JOINT_W    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int TOL_W      = 15;
   localparam int DWELL_W    = 16;
   localparam int SKIP_W     = 16;
   localparam int STEPS_W    = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PORT_ROW_W = 4;
   localparam int CMP_W      = ((POS_W + 1) > TOL_W) ? (POS_W + 1) : TOL_W;

   localparam logic [TOL_W-1:0]          ROT_TOL_RESET = TOL_W'(2);
   localparam logic [TOL_W-1:0]          LIN_TOL_RESET = TOL_W'(2);
   localparam logic [JOINTS-1:0]         LIN_MASK_RESET = '0;
   localparam logic [DWELL_W-1:0]        DWELL_RESET = DWELL_W'(5000);
   localparam logic signed [SKIP_W-1:0]  SKIP1_RESET = SKIP_W'(140);
   localparam logic signed [SKIP_W-1:0]  SKIP2_RESET = SKIP_W'(100);
   localparam logic [STEPS_W-1:0]        STEPS_RESET = STEPS_W'(16);

   typedef logic signed [POS_W-1:0] pos_type;
   typedef logic [ROW_W-1:0]        row_type;
   typedef pos_type [JOINTS-1:0]    row_data_type;

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_START = 2'd1,
      MODE_TICK  = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROT_TOL  = 3'd0,
      CSR_LIN_TOL  = 3'd1,
      CSR_LIN_MASK = 3'd2,
      CSR_DWELL    = 3'd3,
      CSR_SKIP1    = 3'd4,
      CSR_SKIP2    = 3'd5,
      CSR_STEPS    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TOL_W-1:0]         rotary_tolerance;
      logic [TOL_W-1:0]         linear_tolerance;
      logic [JOINTS-1:0]        linear_joint_mask;
      logic [DWELL_W-1:0]       dwell_ticks;
      logic signed [SKIP_W-1:0] skip_value_joint1;
      logic signed [SKIP_W-1:0] skip_value_joint2;
      logic [STEPS_W-1:0]       steps_in_use;
   } cfg_type;

   typedef struct packed {
      row_data_type targets;
      row_type      row;
      logic         running;
      logic         advanced;
      logic         finished;
   } result_type;

endpackage

>>> rtl/joint_waypoint_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_waypoint_sequencer
// Steps a multi-joint arm through a table of waypoint rows with dwell and skip.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  mode, load row/joint/value, positions
//  rsp      out        rsp_valid / rsp_ready  targets, step_now, running, advanced, finished
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
//  one request per cycle unless rsp stalls; a request passes stage 1, then the rsp register
//  the table is read at acceptance through two row ports (active and next row)
//  and the row decision of the request ahead is forwarded to those addresses
//  reset clears sequencer state and registers; table contents stay undefined
//  rsp_ready low holds the response, one more request waits in stage 1
// ----------------------------------------------------------------------------

module joint_waypoint_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [3:0]                          req_load_row,
   input  logic [1:0]                          req_load_joint,
   input  logic signed [15:0]                  req_load_value,
   input  logic signed [15:0]                  req_position_0,
   input  logic signed [15:0]                  req_position_1,
   input  logic signed [15:0]                  req_position_2,
   input  logic signed [15:0]                  req_position_3,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_target_0,
   output logic signed [15:0]                  rsp_target_1,
   output logic signed [15:0]                  rsp_target_2,
   output logic signed [15:0]                  rsp_target_3,
   output logic [3:0]                          rsp_step_now,
   output logic                                rsp_running,
   output logic                                rsp_advanced,
   output logic                                rsp_finished,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jws_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [jws_pkg::CSR_DATA_W-1:0]      csr_data
);

   jws_pkg::cfg_type      cfg;
   jws_pkg::row_data_type rd_cur;
   jws_pkg::row_data_type rd_next;
   jws_pkg::row_type      row_addr;
   jws_pkg::row_type      addr_next;
   jws_pkg::result_type   result;

   logic signed [15:0]    port_pos [jws_pkg::PORT_JOINTS];
   jws_pkg::row_data_type req_pos;
   logic signed [15:0]    out_target [jws_pkg::PORT_JOINTS];

   logic                  req_fire;
   logic                  wr_en;
   logic                  s1_fire;

   logic                  s1_valid_ff;
   logic [1:0]            s1_mode_ff;
   jws_pkg::row_data_type s1_pos_ff;

   logic                  rsp_valid_ff;
   jws_pkg::result_type   result_ff;

   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      port_pos[0] = req_position_0;
      port_pos[1] = req_position_1;
      port_pos[2] = req_position_2;
      port_pos[3] = req_position_3;
      req_pos = '0;
      for (int j = 0; j < jws_pkg::JOINTS; j++) begin
         req_pos[j] = jws_pkg::POS_W'(port_pos[j]);
      end
   end

   // loads go straight into the table at acceptance
   assign wr_en = req_fire && (req_mode == jws_pkg::MODE_LOAD) &&
                  (int'(req_load_row) < jws_pkg::STEPS) &&
                  (int'(req_load_joint) < jws_pkg::JOINTS);

   always_comb begin
      if (req_mode == jws_pkg::MODE_START) begin
         addr_next = '0;
      end else if (row_addr == jws_pkg::ROW_W'(jws_pkg::STEPS - 1)) begin
         addr_next = '0;
      end else begin
         addr_next = row_addr + 1'b1;
      end
   end

   jws_table u_table (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_row       (jws_pkg::ROW_W'(req_load_row)),
      .wr_joint     (jws_pkg::JOINT_W'(req_load_joint)),
      .wr_data      (jws_pkg::POS_W'(req_load_value)),
      .rd_en        (req_fire),
      .rd_addr_cur  (row_addr),
      .rd_addr_next (addr_next),
      .rd_cur       (rd_cur),
      .rd_next      (rd_next)
   );

   jws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff <= req_mode;
         s1_pos_ff  <= req_pos;
      end
   end

   jws_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_fire),
      .mode      (jws_pkg::mode_type'(s1_mode_ff)),
      .positions (s1_pos_ff),
      .cfg       (cfg),
      .rd_cur    (rd_cur),
      .rd_next   (rd_next),
      .row_addr  (row_addr),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         result_ff <= result;
      end
   end

   // joints the build does not have read as zero
   always_comb begin
      for (int j = 0; j < jws_pkg::PORT_JOINTS; j++) begin
         out_target[j] = '0;
         if (j < jws_pkg::JOINTS) begin
            out_target[j] = 16'($signed(result_ff.targets[j]));
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_target_0 = out_target[0];
   assign rsp_target_1 = out_target[1];
   assign rsp_target_2 = out_target[2];
   assign rsp_target_3 = out_target[3];
   assign rsp_step_now = jws_pkg::PORT_ROW_W'(result_ff.row);
   assign rsp_running  = result_ff.running;
   assign rsp_advanced = result_ff.advanced;
   assign rsp_finished = result_ff.finished;

endmodule

>>> rtl/jws_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jws_table
// Waypoint table: one write port for a single entry, two registered row read ports.
// ----------------------------------------------------------------------------

module jws_table (
   input  logic                  clock,
   input  logic                  wr_en,
   input  jws_pkg::row_type      wr_row,
   input  logic [jws_pkg::JOINT_W-1:0] wr_joint,
   input  jws_pkg::pos_type      wr_data,
   input  logic                  rd_en,
   input  jws_pkg::row_type      rd_addr_cur,
   input  jws_pkg::row_type      rd_addr_next,
   output jws_pkg::row_data_type rd_cur,
   output jws_pkg::row_data_type rd_next
);

   jws_pkg::pos_type      mem [jws_pkg::STEPS][jws_pkg::JOINTS];
   jws_pkg::row_data_type rd_cur_ff;
   jws_pkg::row_data_type rd_next_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_joint] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         for (int j = 0; j < jws_pkg::JOINTS; j++) begin
            rd_cur_ff[j]  <= mem[rd_addr_cur][j];
            rd_next_ff[j] <= mem[rd_addr_next][j];
         end
      end
   end

   assign rd_cur  = rd_cur_ff;
   assign rd_next = rd_next_ff;

endmodule

>>> rtl/jws_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jws_csr
// Configuration registers of the sequencer, written through the csr channel.
// ----------------------------------------------------------------------------

module jws_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jws_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jws_pkg::CSR_DATA_W-1:0]   csr_data,
   output jws_pkg::cfg_type                 cfg
);

   jws_pkg::cfg_type cfg_ff;
   jws_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            jws_pkg::CSR_ROT_TOL:  cfg_in.rotary_tolerance  = csr_data[jws_pkg::TOL_W-1:0];
            jws_pkg::CSR_LIN_TOL:  cfg_in.linear_tolerance  = csr_data[jws_pkg::TOL_W-1:0];
            jws_pkg::CSR_LIN_MASK: cfg_in.linear_joint_mask = csr_data[jws_pkg::JOINTS-1:0];
            jws_pkg::CSR_DWELL:    cfg_in.dwell_ticks       = csr_data[jws_pkg::DWELL_W-1:0];
            jws_pkg::CSR_SKIP1:    cfg_in.skip_value_joint1 = csr_data[jws_pkg::SKIP_W-1:0];
            jws_pkg::CSR_SKIP2:    cfg_in.skip_value_joint2 = csr_data[jws_pkg::SKIP_W-1:0];
            jws_pkg::CSR_STEPS:    cfg_in.steps_in_use      = csr_data[jws_pkg::STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotary_tolerance  <= jws_pkg::ROT_TOL_RESET;
         cfg_ff.linear_tolerance  <= jws_pkg::LIN_TOL_RESET;
         cfg_ff.linear_joint_mask <= jws_pkg::LIN_MASK_RESET;
         cfg_ff.dwell_ticks       <= jws_pkg::DWELL_RESET;
         cfg_ff.skip_value_joint1 <= jws_pkg::SKIP1_RESET;
         cfg_ff.skip_value_joint2 <= jws_pkg::SKIP2_RESET;
         cfg_ff.steps_in_use      <= jws_pkg::STEPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

>>> rtl/jws_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jws_seq
// Sequencer state and step logic: tolerance check, dwell count, row advance.
// ----------------------------------------------------------------------------

module jws_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  jws_pkg::mode_type     mode,
   input  jws_pkg::row_data_type positions,
   input  jws_pkg::cfg_type      cfg,
   input  jws_pkg::row_data_type rd_cur,
   input  jws_pkg::row_data_type rd_next,
   output jws_pkg::row_type      row_addr,
   output jws_pkg::result_type   result
);

   jws_pkg::row_data_type          targets_ff, targets_in;
   jws_pkg::row_type               row_ff, row_in;
   logic                           running_ff, running_in;
   logic                           armed_ff, armed_in;
   logic [jws_pkg::DWELL_W-1:0]    count_ff, count_in;
   logic [jws_pkg::DWELL_W-1:0]    count_inc;
   logic                           advanced;
   logic                           finished;

   logic signed [jws_pkg::POS_W:0] diff [jws_pkg::JOINTS];
   logic [jws_pkg::POS_W:0]        mag [jws_pkg::JOINTS];
   logic [jws_pkg::TOL_W-1:0]      tol [jws_pkg::JOINTS];
   logic                           reached;
   logic                           skip;
   logic [jws_pkg::STEPS_W-1:0]    limit;
   logic                           last_row;

   // per-joint |target - position| against that joint's tolerance
   always_comb begin
      reached = 1'b1;
      for (int j = 0; j < jws_pkg::JOINTS; j++) begin
         diff[j] = (jws_pkg::POS_W+1)'($signed(targets_ff[j]))
                 - (jws_pkg::POS_W+1)'($signed(positions[j]));
         mag[j]  = diff[j][jws_pkg::POS_W] ? -diff[j] : diff[j];
         tol[j]  = cfg.linear_joint_mask[j] ? cfg.linear_tolerance : cfg.rotary_tolerance;
         if (jws_pkg::CMP_W'(mag[j]) > jws_pkg::CMP_W'(tol[j])) begin
            reached = 1'b0;
         end
      end
   end

   assign skip = ($signed(rd_cur[1]) == cfg.skip_value_joint1) ||
                 ($signed(rd_cur[2]) == cfg.skip_value_joint2);

   assign count_inc = (count_ff == '1) ? count_ff : count_ff + 1'b1;

   // zero rows in use acts as one, anything above the table acts as full
   always_comb begin
      if (cfg.steps_in_use == '0) begin
         limit = jws_pkg::STEPS_W'(1);
      end else if (cfg.steps_in_use > jws_pkg::STEPS_W'(jws_pkg::STEPS)) begin
         limit = jws_pkg::STEPS_W'(jws_pkg::STEPS);
      end else begin
         limit = cfg.steps_in_use;
      end
   end

   assign last_row = (jws_pkg::STEPS_W'(row_ff) + jws_pkg::STEPS_W'(1)) >= limit;

   always_comb begin
      targets_in = targets_ff;
      row_in     = row_ff;
      running_in = running_ff;
      armed_in   = armed_ff;
      count_in   = count_ff;
      advanced   = 1'b0;
      finished   = 1'b0;
      case (mode)
         jws_pkg::MODE_START: begin
            row_in     = '0;
            armed_in   = 1'b0;
            count_in   = '0;
            running_in = 1'b1;
            targets_in = rd_next;
         end
         jws_pkg::MODE_TICK: begin
            if (running_ff) begin
               if (!reached) begin
                  armed_in = 1'b0;
                  count_in = '0;
               end else if (!armed_ff) begin
                  // arming tick never advances
                  armed_in = 1'b1;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
                  if (skip || (count_inc >= cfg.dwell_ticks)) begin
                     armed_in = 1'b0;
                     count_in = '0;
                     if (last_row) begin
                        row_in     = '0;
                        running_in = 1'b0;
                        finished   = 1'b1;
                     end else begin
                        row_in     = row_ff + 1'b1;
                        targets_in = rd_next;
                        advanced   = 1'b1;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         targets_ff <= '0;
         row_ff     <= '0;
         running_ff <= 1'b0;
         armed_ff   <= 1'b0;
         count_ff   <= '0;
      end else if (fire) begin
         targets_ff <= targets_in;
         row_ff     <= row_in;
         running_ff <= running_in;
         armed_ff   <= armed_in;
         count_ff   <= count_in;
      end
   end

   // row the next request sees, used to address the table at acceptance
   assign row_addr = fire ? row_in : row_ff;

   assign result.targets  = targets_in;
   assign result.row      = row_in;
   assign result.running  = running_in;
   assign result.advanced = advanced;
   assign result.finished = finished;

endmodule

>>> rtl/jws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jws_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------

module jws_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_target_0,
   input logic signed [15:0] rsp_target_1,
   input logic signed [15:0] rsp_target_2,
   input logic signed [15:0] rsp_target_3,
   input logic [3:0]         rsp_step_now,
   input logic               rsp_running,
   input logic               rsp_advanced,
   input logic               rsp_finished
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target_0) &&
      $stable(rsp_target_1) && $stable(rsp_target_2) && $stable(rsp_target_3) &&
      $stable(rsp_step_now) && $stable(rsp_running) && $stable(rsp_advanced) &&
      $stable(rsp_finished))
      else $error("response changed while stalled");

   // the request side only backs up behind a stalled response
   a_req_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request stalled without a stalled response");

   a_adv_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_advanced |-> rsp_running && !rsp_finished && rsp_step_now != 4'd0)
      else $error("advance outside a running sequence");

   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> !rsp_running && rsp_step_now == 4'd0)
      else $error("finish left the sequence active");

   a_idle_row0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_running |-> rsp_step_now == 4'd0)
      else $error("idle sequencer reports a nonzero row");

endmodule

bind joint_waypoint_sequencer jws_checker u_jws_checker (.*);
